### src/usan_pkg.sv
// ----------------------------------------------------------------------------
// usan_pkg
// Shared types, constants and byte-class helpers of the UTF-8 sanitizer.
// ----------------------------------------------------------------------------
package usan_pkg;

  localparam int MAX_BURST             = 4;  // most bytes one input can cause
  localparam int QUEUE_DEPTH           = 4;  // bursts between front and back
  localparam int DEF_MAX_REPL_BYTES    = 4;

  // configuration register indexes
  localparam logic [1:0] REG_REPLACE_MODE = 2'd0;
  localparam logic [1:0] REG_REPL_BYTES   = 2'd1;
  localparam logic [1:0] REG_REPL_LENGTH  = 2'd2;

  // reset values of the configuration registers
  localparam logic        RST_REPLACE_MODE = 1'b0;
  localparam logic [31:0] RST_REPL_BYTES   = 32'd63;
  localparam logic [2:0]  RST_REPL_LENGTH  = 3'd1;

  typedef struct packed {
    logic        replace_mode;
    logic [31:0] repl_bytes;
    logic [2:0]  repl_length;
  } cfg_t;

  // one input's worth of output bytes, packed from slot 0
  typedef struct packed {
    logic [MAX_BURST-1:0][7:0] bytes;
    logic [2:0]                count;  // 0..MAX_BURST
    logic                      last;   // input was the string's final byte
  } burst_t;

  // followers a lead byte asks for; 0 when b is not a lead byte
  function automatic logic [1:0] lead_followers(input logic [7:0] b);
    logic [1:0] n;
    n = 2'd0;
    if (b inside {[8'hC0:8'hDF]}) n = 2'd1;
    else if (b inside {[8'hE0:8'hEF]}) n = 2'd2;
    else if (b inside {[8'hF0:8'hF7]}) n = 2'd3;
    return n;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

endpackage

### src/usan_front.sv
// ----------------------------------------------------------------------------
// usan_front
// Classifies each input byte, tracks the open multibyte window and builds
// the burst of output bytes that the byte completes.
// ----------------------------------------------------------------------------
module usan_front #(
  parameter int MAX_REPLACEMENT_BYTES = usan_pkg::DEF_MAX_REPL_BYTES
) (
  input  logic            clk,
  input  logic            rst,
  input  usan_pkg::cfg_t  cfg,
  input  logic            accept,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  output logic            push,
  output usan_pkg::burst_t burst
);
  import usan_pkg::*;

  localparam int CAP_INT = (MAX_REPLACEMENT_BYTES < MAX_BURST) ?
                           MAX_REPLACEMENT_BYTES : MAX_BURST;
  localparam logic [2:0] REPL_CAP = 3'(CAP_INT);

  logic       win_open;
  logic [1:0] win_need;
  logic [1:0] win_got;
  logic [7:0] lead;
  logic [7:0] held_fol [0:1];  // third follower is always the current byte

  logic [1:0]           new_need;
  logic                 complete;
  logic [2:0]           got_inc;
  logic [7:0]           fol [0:2];
  logic [2:0]           fol_ok;
  logic                 win_ok;
  logic [2:0]           rlen;
  logic [MAX_BURST-1:0][7:0] cand;
  logic [MAX_BURST-1:0] keep;
  logic [MAX_BURST-1:0][7:0] packed_bytes;
  logic [2:0]           cnt;

  assign new_need = lead_followers(in_byte);
  assign got_inc  = {1'b0, win_got} + 3'd1;
  assign complete = win_open && (got_inc >= {1'b0, win_need});
  assign rlen     = (cfg.repl_length > REPL_CAP) ? REPL_CAP : cfg.repl_length;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      fol[i] = (2'(i) == win_got) ? in_byte : held_fol[i];
    end
    fol[2] = in_byte;
    for (int i = 0; i < 3; i++) begin
      fol_ok[i] = is_cont(fol[i]) || (2'(i) >= win_need);
    end
    win_ok = &fol_ok;
  end

  // candidates and keep mask, then pack the kept bytes from slot 0
  always_comb begin
    cand = '0;
    keep = '0;
    if (!win_open) begin
      cand[0] = in_byte;
      keep[0] = (new_need == 2'd0);
    end else if (complete && win_ok && cfg.replace_mode) begin
      for (int i = 0; i < MAX_BURST; i++) begin
        cand[i] = cfg.repl_bytes[8*i +: 8];
        keep[i] = 3'(i) < rlen;
      end
    end else if (complete && win_ok) begin
      cand[0] = lead;
      keep[0] = 1'b1;
      for (int i = 0; i < 3; i++) begin
        cand[i+1] = fol[i];
        keep[i+1] = 2'(i) < win_need;
      end
    end else if (complete) begin
      for (int i = 0; i < 3; i++) begin
        cand[i] = fol[i];
        keep[i] = (2'(i) < win_need) && !fol[i][7];
      end
    end
  end

  always_comb begin
    packed_bytes = '0;
    cnt          = 3'd0;
    for (int i = 0; i < MAX_BURST; i++) begin
      if (keep[i]) begin
        packed_bytes[cnt[1:0]] = cand[i];
        cnt = cnt + 3'd1;
      end
    end
  end

  assign push        = accept && ((cnt != 3'd0) || in_last);
  assign burst.bytes = packed_bytes;
  assign burst.count = cnt;
  assign burst.last  = in_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_open <= 1'b0;
      win_need <= 2'd0;
      win_got  <= 2'd0;
      lead     <= 8'd0;
    end else if (accept) begin
      if (win_open) begin
        if (complete || in_last) begin
          win_open <= 1'b0;
          win_need <= 2'd0;
          win_got  <= 2'd0;
        end else begin
          win_got <= got_inc[1:0];
        end
      end else if ((new_need != 2'd0) && !in_last) begin
        win_open <= 1'b1;
        win_need <= new_need;
        win_got  <= 2'd0;
        lead     <= in_byte;
      end
    end
  end

  // follower store, no reset: always written before read
  always_ff @(posedge clk) begin
    if (accept && win_open && !complete && !win_got[1]) begin
      held_fol[win_got[0]] <= in_byte;
    end
  end

endmodule

### src/usan_fifo.sv
// ----------------------------------------------------------------------------
// usan_fifo
// Short burst queue between the front and the back.
// ----------------------------------------------------------------------------
module usan_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  usan_pkg::burst_t wr_data,
  input  logic             pop,
  output usan_pkg::burst_t head,
  output logic             empty,
  output logic             full
);
  import usan_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  burst_t        entries [0:QUEUE_DEPTH-1];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  assign empty = (fill == '0);
  assign full  = (fill == DEPTH_C);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) fill <= fill + CW'(1);
      else if (pop && !push) fill <= fill - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push || pop)
    else $error("burst queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("burst queue underflow");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= DEPTH_C)
    else $error("burst queue fill out of range");

endmodule

### src/usan_back.sv
// ----------------------------------------------------------------------------
// usan_back
// Walks the burst at the queue head one byte per beat into the output
// register; an empty final burst becomes a single end marker.
// ----------------------------------------------------------------------------
module usan_back (
  input  logic             clk,
  input  logic             rst,
  input  usan_pkg::burst_t head,
  input  logic             empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             byte_valid,
  output logic             run_last,
  output logic             string_end
);
  import usan_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       beat_last;
  logic       has_data;

  assign has_data  = (head.count != 3'd0);
  assign beat_last = !has_data || (({1'b0, idx} + 3'd1) == head.count);
  assign load      = !empty && (!out_valid || !out_stall);
  assign pop       = load && beat_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= beat_last ? 2'd0 : idx + 2'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= has_data ? head.bytes[idx] : 8'd0;
      byte_valid <= has_data;
      run_last   <= beat_last;
      string_end <= beat_last && head.last;
    end
  end

  a_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_end |-> run_last)
    else $error("string end without run end");

  a_marker_is_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> run_last && string_end)
    else $error("empty marker not final");

endmodule

### src/utf8_stream_sanitizer.sv
// An accepted byte's burst is written into the burst queue, and its first beat then into the output register.
// Throughput: one input byte per cycle while the burst queue has room; the
// output side moves one beat per cycle while out_stall is low, so a byte
// causing k bytes needs k beats and the 4-entry burst queue absorbs the difference.
// Reset (rst, synchronous): window closed, queue and output emptied,
// registers back to replace_mode 0, replacement_bytes 63, replacement_length 1.
// ----------------------------------------------------------------------------
// utf8_stream_sanitizer
// Byte-serial UTF-8 filter: front classifies and builds bursts, back emits.
// ----------------------------------------------------------------------------
module utf8_stream_sanitizer #(
  parameter int MAX_REPLACEMENT_BYTES = usan_pkg::DEF_MAX_REPL_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input byte channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  // output beat channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        run_last,
  output logic        string_end
);
  import usan_pkg::*;

  cfg_t   cfg;
  burst_t wr_burst;
  burst_t head;
  logic   accept;
  logic   push;
  logic   pop;
  logic   empty;
  logic   full;

  // register writes are taken every cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.replace_mode <= RST_REPLACE_MODE;
      cfg.repl_bytes   <= RST_REPL_BYTES;
      cfg.repl_length  <= RST_REPL_LENGTH;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_REPLACE_MODE: cfg.replace_mode <= cfg_data[0];
        REG_REPL_BYTES:   cfg.repl_bytes   <= cfg_data;
        REG_REPL_LENGTH:  cfg.repl_length  <= cfg_data[2:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // every accepted beat can push at most one burst, so stall on a full queue
  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  usan_front #(
    .MAX_REPLACEMENT_BYTES(MAX_REPLACEMENT_BYTES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (accept),
    .in_byte (in_byte),
    .in_last (in_last),
    .push    (push),
    .burst   (wr_burst)
  );

  usan_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_burst),
    .pop     (pop),
    .head    (head),
    .empty   (empty),
    .full    (full)
  );

  usan_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .run_last   (run_last),
    .string_end (string_end)
  );

endmodule

### sim/utf8_stream_sanitizer_test.sv
// ----------------------------------------------------------------------------
// utf8_stream_sanitizer_test
// Self-checking bench for the byte-serial UTF-8 sanitizer. A short table of
// directed bytes is walked first, then random strings built mostly from
// well-formed characters, under six register settings. Each output beat is
// compared with a checked row's typed-in beat, else with the behavioral predictor.
// ----------------------------------------------------------------------------
module utf8_stream_sanitizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import usan_pkg::*;

  localparam int         REPL_CAP     = DEF_MAX_REPL_BYTES;
  localparam logic [1:0] REG_UNUSED   = 2'd3;  // index with no register behind it
  localparam int         DRAIN_CYCLES = 8;     // settle time after the last beat
  localparam int         IDLE_LIMIT   = 2000;  // watchdog, cycles with no handshake
  localparam int         PHASE_BYTES  = 31;    // random-byte quota per register setting

  // one output beat as seen on the ports
  typedef struct packed {
    logic [7:0] data;
    logic       has_data;
    logic       burst_end;
    logic       str_end;
  } beat_t;

  localparam beat_t NO_BEAT = '0;

  // one row of the directed table; chk marks rows with a typed-in beat
  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       chk;
    beat_t      want;
  } dir_row_t;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = '0;
  logic [31:0] cfg_data   = '0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte    = '0;
  logic        in_last    = 1'b0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        run_last;
  logic        string_end;

  utf8_stream_sanitizer u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .run_last   (run_last),
    .string_end (string_end)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor: own copy of the window state and of the registers
  // --------------------------------------------------------------------------
  logic        sh_mode = RST_REPLACE_MODE;
  logic [31:0] sh_repl = RST_REPL_BYTES;
  logic [2:0]  sh_len  = RST_REPL_LENGTH;

  logic [7:0]  win_lead = '0;
  logic [7:0]  win_fol [3];
  logic [1:0]  win_need = '0;
  logic [1:0]  win_got  = '0;
  logic        win_open = 1'b0;

  beat_t       burst_beats [$];  // beats caused by the byte just accepted
  beat_t       pending_beats [$]; // expected beats not yet seen on the output
  int          errors = 0;
  int          burst_left = 0;

  function automatic beat_t data_beat(input logic [7:0] b);
    return {b, 1'b1, 1'b0, 1'b0};
  endfunction

  // Works out the beats one input byte causes and advances the window.
  task automatic sanitize_byte(input logic [7:0] b, input logic last);
    int    cnt;
    int    len;
    logic  ok;
    beat_t tail;
    burst_beats.delete();
    if (win_open) begin
      if (win_got < 2'd3) win_fol[win_got] = b;
      win_got = win_got + 2'd1;
      if (win_got >= win_need) begin
        cnt = int'(win_need);
        ok  = 1'b1;
        for (int i = 0; i < cnt; i++)
          if (win_fol[i][7:6] != 2'b10) ok = 1'b0;
        if (ok && sh_mode) begin
          // valid character swapped for the replacement, length clipped
          len = (sh_len > 3'd4) ? 4 : int'(sh_len);
          if (len > REPL_CAP) len = REPL_CAP;
          for (int i = 0; i < len; i++) burst_beats.push_back(data_beat(sh_repl[8*i +: 8]));
        end else if (ok) begin
          burst_beats.push_back(data_beat(win_lead));
          for (int i = 0; i < cnt; i++) burst_beats.push_back(data_beat(win_fol[i]));
        end else begin
          // broken window: only its ASCII followers survive
          for (int i = 0; i < cnt; i++)
            if (!win_fol[i][7]) burst_beats.push_back(data_beat(win_fol[i]));
        end
        win_open = 1'b0;
        win_need = '0;
        win_got  = '0;
      end
    end else if (!b[7] || b[7:6] == 2'b10 || b[7:3] == 5'b11111) begin
      burst_beats.push_back(data_beat(b));   // ASCII, stray continuation, 0xF8+
    end else if (!last) begin
      win_lead = b;
      win_need = (b[7:5] == 3'b110) ? 2'd1 : (b[7:4] == 4'b1110) ? 2'd2 : 2'd3;
      win_got  = '0;
      win_open = 1'b1;
    end
    if (last) begin
      // truncated windows are dropped; the string always ends with a marked beat
      win_open = 1'b0;
      win_need = '0;
      win_got  = '0;
      if (burst_beats.size() == 0) burst_beats.push_back(NO_BEAT);
      tail = burst_beats[burst_beats.size()-1];
      tail.str_end = 1'b1;
      burst_beats[burst_beats.size()-1] = tail;
    end
    if (burst_beats.size() != 0) begin
      tail = burst_beats[burst_beats.size()-1];
      tail.burst_end = 1'b1;
      burst_beats[burst_beats.size()-1] = tail;
    end
  endtask

  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // --------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps in between
  // --------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input logic last,
                           input logic chk, input beat_t want);
    int gap;
    if (burst_left == 0) begin
      // about one burst in four is long, giving stretches with no input idling
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // beat accepted at this edge
    sanitize_byte(b, last);
    if (chk) pending_beats.push_back(want);
    else foreach (burst_beats[i]) pending_beats.push_back(burst_beats[i]);
  endtask

  // Register write; the caller lowers cfg_valid after its last write.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_REPLACE_MODE: sh_mode = data[0];
      REG_REPL_BYTES:   sh_repl = data;
      REG_REPL_LENGTH:  sh_len  = data[2:0];
      default: ;
    endcase
  endtask

  // Wait until every expected beat has come out, then let the block go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random strings: mostly whole characters with random payload bits, plus
  // broken and truncated ones and plain noise. Each phase closes its string.
  task automatic random_strings(input int quota);
    int         sent;
    int         kind;
    int         n;
    int         cut;
    int         r;
    logic [7:0] pc [4];
    sent = 0;
    while (sent < quota) begin
      kind = $urandom_range(0, 99);
      n = 1;
      if (kind < 30) begin
        pc[0] = 8'($urandom_range(0, 127));
      end else if (kind < 72) begin
        n = $urandom_range(2, 4);
        case (n)
          2: pc[0] = 8'(8'hC0 + $urandom_range(0, 31));
          3: pc[0] = 8'(8'hE0 + $urandom_range(0, 15));
          default: pc[0] = 8'(8'hF0 + $urandom_range(0, 7));
        endcase
        for (int i = 1; i < n; i++) pc[i] = 8'(8'h80 + $urandom_range(0, 63));
        if (kind >= 60) pc[$urandom_range(1, n - 1)] = 8'($urandom_range(0, 255));
      end else if (kind < 80) begin
        pc[0] = 8'(8'h80 + $urandom_range(0, 63));
      end else if (kind < 90) begin
        pc[0] = 8'($urandom_range(0, 255));
      end else begin
        pc[0] = 8'(8'hF8 + $urandom_range(0, 7));
      end
      r   = $urandom_range(0, 19);
      cut = -1;
      if (r < 3 && n > 1) begin
        n   = $urandom_range(1, n - 1);   // string ends inside the window
        cut = n - 1;
      end else if (r < 7) begin
        cut = n - 1;
      end
      for (int i = 0; i < n; i++) push_byte(pc[i], i == cut, 1'b0, NO_BEAT);
      sent += n;
    end
    push_byte(8'($urandom_range(0, 127)), 1'b1, 1'b0, NO_BEAT);
  endtask

  // --------------------------------------------------------------------------
  // Directed table, run with the reset register values
  // --------------------------------------------------------------------------
  dir_row_t dir_tab [25] = '{
    '{8'h00, 1'b0, 1'b1, {8'h00, 1'b1, 1'b1, 1'b0}},  // lowest ASCII
    '{8'h7F, 1'b0, 1'b1, {8'h7F, 1'b1, 1'b1, 1'b0}},  // highest ASCII
    '{8'h80, 1'b0, 1'b1, {8'h80, 1'b1, 1'b1, 1'b0}},  // stray continuation
    '{8'hF8, 1'b0, 1'b1, {8'hF8, 1'b1, 1'b1, 1'b0}},  // high byte
    '{8'hFF, 1'b1, 1'b1, {8'hFF, 1'b1, 1'b1, 1'b1}},  // top byte ends a string
    '{8'hC2, 1'b0, 1'b0, NO_BEAT},                    // two-byte character
    '{8'hA9, 1'b0, 1'b0, NO_BEAT},
    '{8'hE2, 1'b0, 1'b0, NO_BEAT},                    // three-byte character
    '{8'h82, 1'b0, 1'b0, NO_BEAT},
    '{8'hAC, 1'b0, 1'b0, NO_BEAT},
    '{8'hF0, 1'b0, 1'b0, NO_BEAT},                    // four-byte character
    '{8'h9F, 1'b0, 1'b0, NO_BEAT},
    '{8'h98, 1'b0, 1'b0, NO_BEAT},
    '{8'h80, 1'b0, 1'b0, NO_BEAT},
    '{8'hC3, 1'b0, 1'b0, NO_BEAT},                    // broken by ASCII
    '{8'h41, 1'b0, 1'b0, NO_BEAT},
    '{8'hE0, 1'b0, 1'b0, NO_BEAT},                    // high byte in window
    '{8'hF5, 1'b0, 1'b0, NO_BEAT},
    '{8'h41, 1'b0, 1'b0, NO_BEAT},
    '{8'hE0, 1'b0, 1'b0, NO_BEAT},                    // lead in window, no beats
    '{8'hC0, 1'b0, 1'b0, NO_BEAT},
    '{8'h80, 1'b0, 1'b0, NO_BEAT},
    '{8'hF0, 1'b0, 1'b0, NO_BEAT},                    // string ends in window
    '{8'h90, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, 1'b1}},
    '{8'hC2, 1'b1, 1'b1, {8'h00, 1'b0, 1'b1, 1'b1}}   // final byte is a lead
  };

  // --------------------------------------------------------------------------
  // Receiver: stall style redrawn each time stall_tick wraps (none, light, heavy, square)
  // --------------------------------------------------------------------------
  logic [5:0] stall_tick  = '0;
  logic [1:0] stall_style = '0;

  always @(posedge clk) begin
    stall_tick <= stall_tick + 6'd1;
    if (stall_tick == '0) stall_style <= 2'($urandom_range(0, 3));
    case (stall_style)
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_tick[2];
    endcase
  end

  // --------------------------------------------------------------------------
  // Output checker: each accepted beat against the oldest expectation
  // --------------------------------------------------------------------------
  beat_t seen_beat;
  beat_t want_beat;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen_beat = {out_byte, byte_valid, run_last, string_end};
      if (pending_beats.size() == 0) begin
        report($sformatf("unexpected beat byte %02h data %b run_last %b end %b",
                         out_byte, byte_valid, run_last, string_end));
      end else begin
        want_beat = pending_beats.pop_front();
        if (seen_beat !== want_beat)
          report($sformatf("got byte %02h data %b run_last %b end %b, want %02h %b %b %b",
                           out_byte, byte_valid, run_last, string_end, want_beat.data,
                           want_beat.has_data, want_beat.burst_end, want_beat.str_end));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any handshake means the block hung
  // --------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("utf8_stream_sanitizer_test NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i])
      push_byte(dir_tab[i].b, dir_tab[i].last, dir_tab[i].chk, dir_tab[i].want);

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: write_reg(REG_REPLACE_MODE, $urandom | 32'h1);  // reset replacement
        1: begin
          write_reg(REG_REPL_BYTES, 32'hFFFF_FFFF);
          write_reg(REG_REPL_LENGTH, 32'd4);
        end
        2: begin
          write_reg(REG_REPL_BYTES, 32'h0);
          write_reg(REG_REPL_LENGTH, 32'd7);              // clips to four
        end
        3: begin
          write_reg(REG_REPL_BYTES, $urandom);
          write_reg(REG_REPL_LENGTH, 32'd0);              // valid chars vanish
        end
        4: begin
          write_reg(REG_REPLACE_MODE, $urandom & ~32'h1);
          write_reg(REG_REPL_BYTES, $urandom);
          write_reg(REG_REPL_LENGTH, 32'd5);
        end
        default: begin
          write_reg(REG_REPLACE_MODE, $urandom);
          write_reg(REG_REPL_BYTES, $urandom);
          write_reg(REG_REPL_LENGTH, $urandom);
          write_reg(REG_UNUSED, $urandom);
        end
      endcase
      cfg_valid <= 1'b0;
      random_strings(PHASE_BYTES);
    end

    settle();
    if (errors == 0) begin
      $display("utf8_stream_sanitizer_test OK");
    end else begin
      $display("utf8_stream_sanitizer_test NOT OK");
    end
    $finish;
  end

endmodule
